// File: design/countdown_dot_matrix_display_assert.svh
// Assertion macros shared by the countdown display RTL.
`ifndef COUNTDOWN_DOT_MATRIX_DISPLAY_ASSERT_SVH
`define COUNTDOWN_DOT_MATRIX_DISPLAY_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define CDMD_ASSERT_NOW(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define CDMD_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error(msg);

`endif

// File: design/cdmd_pkg.sv
// Shared types, constants and glyph font for the countdown dot-matrix display.
`timescale 1ns / 1ps

package cdmd_pkg;

   localparam int unsigned SECONDS_W   = 13;
   localparam int unsigned MINUTES_W   = 7;
   localparam int unsigned SECS_W      = 6;
   localparam int unsigned DIGIT_W     = 4;
   localparam int unsigned ROW_W       = 3;
   localparam int unsigned PIXELS_W    = 15;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [SECONDS_W-1:0] MAX_SECONDS = 13'd5999;
   localparam logic [ROW_W-1:0]     LAST_ROW    = 3'd7;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   typedef struct packed {
      logic                 kind;
      logic [SECONDS_W-1:0] load_seconds;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0]     row_index;
      logic [PIXELS_W-1:0]  row_pixels;
      logic [SECONDS_W-1:0] remaining;
      logic                 last_row;
   } rsp_type;

   // one picture waiting to be drawn
   typedef struct packed {
      logic [SECONDS_W-1:0] remaining;
      logic [MINUTES_W-1:0] minutes;
      logic [SECS_W-1:0]    seconds;
   } job_type;

   // eight 3-pixel rows, index 0 = top row, leftmost pixel in bit 2
   typedef logic [7:0][2:0] glyph_type;

   // octal literals read bottom row first, one octal digit per row
   localparam glyph_type COLON_GLYPH = 24'o00200200;

   function automatic glyph_type digit_glyph(input logic [DIGIT_W-1:0] digit);
      glyph_type g;
      case (digit)
         4'd0:    g = 24'o75555557;
         4'd1:    g = 24'o72222262;
         4'd2:    g = 24'o74422157;
         4'd3:    g = 24'o71117117;
         4'd4:    g = 24'o11175555;
         4'd5:    g = 24'o71117447;
         4'd6:    g = 24'o75574447;
         4'd7:    g = 24'o11111117;
         4'd8:    g = 24'o75557557;
         4'd9:    g = 24'o11117557;
         default: g = '0;
      endcase
      return g;
   endfunction

endpackage

// File: design/cdmd_front.sv
// Front end: takes requests, keeps the seconds count, queues pictures to draw.
`timescale 1ns / 1ps

module cdmd_front
   import cdmd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    push_valid,
   input  logic    push_ready,
   output job_type push_data
);

   logic [SECONDS_W-1:0] count_ff, count_in;
   logic                 accept;
   logic                 count_zero;
   logic [26:0]          min_prod;
   logic [MINUTES_W-1:0] minutes;
   logic [SECONDS_W-1:0] min_x60;
   logic [SECONDS_W-1:0] sec_full;

   // loads never need queue space, but a shared ready keeps the order simple
   assign req_ready  = push_ready;
   assign accept     = req_valid && req_ready;
   assign count_zero = (count_ff == '0);

   // minutes = count / 60 as count * 8739 >> 19, exact up to 5999
   assign min_prod = 27'(count_ff) * 27'd8739;
   assign minutes  = min_prod[25:19];
   assign min_x60  = {minutes, 6'b0} - {4'b0, minutes, 2'b0};
   assign sec_full = count_ff - min_x60;

   assign push_valid          = accept && (req_data.kind == KIND_TICK) && !count_zero;
   assign push_data.remaining = count_ff;
   assign push_data.minutes   = minutes;
   assign push_data.seconds   = sec_full[SECS_W-1:0];

   // count update: saturating load, decrement after a drawn tick
   always_comb begin
      count_in = count_ff;
      if (accept) begin
         if (req_data.kind == KIND_LOAD) begin
            count_in = (req_data.load_seconds > MAX_SECONDS) ? MAX_SECONDS
                                                             : req_data.load_seconds;
         end else if (!count_zero) begin
            count_in = count_ff - 13'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// File: design/cdmd_queue.sv
// Small flop-based FIFO of pictures between the front and back ends.
`timescale 1ns / 1ps

module cdmd_queue
   import cdmd_pkg::*;
#(
   parameter int unsigned Depth = QUEUE_DEPTH  // 2 or more
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_data
);

   localparam int unsigned PtrW = $clog2(Depth);
   localparam int unsigned CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   job_type         entry_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] fill_ff, fill_in;
   logic            do_push, do_pop;

   assign push_ready = (fill_ff != FullCnt);
   assign pop_valid  = (fill_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: design/cdmd_back.sv
// Back end: splits a queued picture into digits and streams its eight rows.
`timescale 1ns / 1ps

module cdmd_back
   import cdmd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    pop_valid,
   output logic    pop_ready,
   input  job_type pop_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic                 active_ff, active_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   glyph_type            glyph_ff [4];
   logic [SECONDS_W-1:0] remaining_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   logic                 advance, emit, done, take;
   logic [14:0]          min_prod, sec_prod;
   logic [DIGIT_W-1:0]   min_tens, min_ones, sec_tens, sec_ones;
   logic [MINUTES_W-1:0] min_rem;
   logic [SECS_W-1:0]    sec_rem;
   logic [PIXELS_W-1:0]  pixels;

   // value / 10 as value * 205 >> 11, exact for these ranges
   assign min_prod = 15'(pop_data.minutes) * 15'd205;
   assign sec_prod = 15'(pop_data.seconds) * 15'd205;
   assign min_tens = min_prod[14:11];
   assign sec_tens = sec_prod[14:11];
   assign min_rem  = pop_data.minutes - ({3'b0, min_tens} << 3) - ({3'b0, min_tens} << 1);
   assign sec_rem  = pop_data.seconds - ({2'b0, sec_tens} << 3) - ({2'b0, sec_tens} << 1);
   assign min_ones = min_rem[DIGIT_W-1:0];
   assign sec_ones = sec_rem[DIGIT_W-1:0];

   // output stage moves when empty or taken
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign emit      = active_ff && advance;
   assign done      = emit && (row_ff == LAST_ROW);
   assign take      = pop_valid && pop_ready;
   assign pop_ready = !active_ff || done;

   assign pixels = {glyph_ff[0][row_ff], glyph_ff[1][row_ff], COLON_GLYPH[row_ff],
                    glyph_ff[2][row_ff], glyph_ff[3][row_ff]};

   // row sequencer
   always_comb begin
      active_in = active_ff;
      row_in    = row_ff;
      if (take) begin
         active_in = 1'b1;
         row_in    = '0;
      end else if (done) begin
         active_in = 1'b0;
      end else if (emit) begin
         row_in = row_ff + ROW_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         row_ff    <= row_in;
         if (advance) begin
            rsp_valid_ff <= active_ff;
         end
      end
   end

   // picture and output payload
   always_ff @(posedge clock) begin
      if (take) begin
         glyph_ff[0]  <= digit_glyph(min_tens);
         glyph_ff[1]  <= digit_glyph(min_ones);
         glyph_ff[2]  <= digit_glyph(sec_tens);
         glyph_ff[3]  <= digit_glyph(sec_ones);
         remaining_ff <= pop_data.remaining;
      end
      if (emit) begin
         rsp_ff.row_index  <= row_ff;
         rsp_ff.row_pixels <= pixels;
         rsp_ff.remaining  <= remaining_ff;
         rsp_ff.last_row   <= (row_ff == LAST_ROW);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: design/countdown_dot_matrix_display.sv
// Top level of the countdown timer with MM:SS dot-matrix rows.
//
// Requests arrive on req_ (valid/ready). kind 0 loads the seconds count,
// saturating at 5999; it produces no rows. kind 1 is a one-second tick:
// with a non-zero count it yields eight rows on rsp_ (row 0 first, last_row
// on row 7) showing the count as MM:SS, then decrements; at zero it yields
// nothing. Each row carries 15 pixels and the count shown.
// A tick's picture is registered in the queue, then in the back end's glyph
// registers, and each row in the output stage. Throughput: one row per cycle
// while rsp_ready is high, set by the back end's row sequencer; the queue
// between front and back lets up to QueueDepth further ticks be accepted
// while rows are still streaming. Loads are accepted whenever the queue
// has space. Reset (synchronous) clears the count to zero and empties the
// queue and output stage. A stalled receiver holds the current row; the
// back end then stops, the queue fills and req_ready drops.
`timescale 1ns / 1ps

`include "countdown_dot_matrix_display_assert.svh"

module countdown_dot_matrix_display
   import cdmd_pkg::*;
#(
   parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    push_valid, push_ready;
   job_type push_data;
   logic    pop_valid, pop_ready;
   job_type pop_data;

   cdmd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   cdmd_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   cdmd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // rows of one picture follow without gaps and in order
   `CDMD_ASSERT_NEXT(a_rows_contiguous, clock, reset, rsp_valid && rsp_ready && !rsp_data.last_row, rsp_valid, "row stream broke inside a picture")
   `CDMD_ASSERT_NEXT(a_row_order, clock, reset, rsp_valid && rsp_ready && !rsp_data.last_row, rsp_data.row_index == 3'($past(rsp_data.row_index) + 3'd1), "row index did not step by one")
   `CDMD_ASSERT_NOW(a_last_row_flag, clock, reset, rsp_valid, rsp_data.last_row == (rsp_data.row_index == LAST_ROW), "last_row out of step with row index")
   `CDMD_ASSERT_NOW(a_nonzero_shown, clock, reset, rsp_valid, rsp_data.remaining != '0, "picture drawn for a zero count")

endmodule
